>>> design/rc2_pkg.sv
// ----------------------------------------------------------------------------
// rc2_pkg
// Shared types, codes and constants of the RC2 engine: key store geometry,
// operation codes, sequencer states and the PITABLE permutation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rc2_pkg;

    localparam int KEY_BYTES  = 128;
    localparam int KEY_AW     = $clog2(KEY_BYTES);
    localparam int SK_AW      = KEY_AW - 1;
    localparam int WORD_W     = 16;
    localparam int BLOCK_W    = 64;
    localparam int CFG_DATA_W = 11;

    localparam logic [7:0]  KEY_LENGTH_RST = 8'd8;
    localparam logic [10:0] EFF_BITS_RST   = 11'd64;
    localparam logic [7:0]  KEY_LEN_MAX    = 8'd128;
    localparam logic [10:0] EFF_BITS_MAX   = 11'd1024;

    // round positions of the two mashing rounds and the last round
    localparam logic [4:0] MASH_RND_A = 5'd5;
    localparam logic [4:0] MASH_RND_B = 5'd12;
    localparam logic [4:0] LAST_RND   = 5'd17;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_EXPAND  = 2'd1,
        OP_ENCRYPT = 2'd2,
        OP_DECRYPT = 2'd3
    } op_t;

    typedef enum logic {
        CFG_KEY_LENGTH = 1'b0,
        CFG_EFF_BITS   = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_BLOCK,
        ST_RESULT
    } state_t;

    typedef enum logic [1:0] {
        EXP_FWD,
        EXP_MASK,
        EXP_BWD,
        EXP_DONE
    } exp_phase_t;

    typedef struct packed {
        logic              en;
        logic [KEY_AW-1:0] addr;
        logic [7:0]        data;
    } mem_wr_t;

    typedef struct packed {
        logic       decrypt;
        logic       mash;
        logic [1:0] word;
    } rnd_ctl_t;

    typedef logic [3:0][WORD_W-1:0] words_t;

    localparam logic [7:0] PITABLE [256] = '{
        8'hd9, 8'h78, 8'hf9, 8'hc4, 8'h19, 8'hdd, 8'hb5, 8'hed,
        8'h28, 8'he9, 8'hfd, 8'h79, 8'h4a, 8'ha0, 8'hd8, 8'h9d,
        8'hc6, 8'h7e, 8'h37, 8'h83, 8'h2b, 8'h76, 8'h53, 8'h8e,
        8'h62, 8'h4c, 8'h64, 8'h88, 8'h44, 8'h8b, 8'hfb, 8'ha2,
        8'h17, 8'h9a, 8'h59, 8'hf5, 8'h87, 8'hb3, 8'h4f, 8'h13,
        8'h61, 8'h45, 8'h6d, 8'h8d, 8'h09, 8'h81, 8'h7d, 8'h32,
        8'hbd, 8'h8f, 8'h40, 8'heb, 8'h86, 8'hb7, 8'h7b, 8'h0b,
        8'hf0, 8'h95, 8'h21, 8'h22, 8'h5c, 8'h6b, 8'h4e, 8'h82,
        8'h54, 8'hd6, 8'h65, 8'h93, 8'hce, 8'h60, 8'hb2, 8'h1c,
        8'h73, 8'h56, 8'hc0, 8'h14, 8'ha7, 8'h8c, 8'hf1, 8'hdc,
        8'h12, 8'h75, 8'hca, 8'h1f, 8'h3b, 8'hbe, 8'he4, 8'hd1,
        8'h42, 8'h3d, 8'hd4, 8'h30, 8'ha3, 8'h3c, 8'hb6, 8'h26,
        8'h6f, 8'hbf, 8'h0e, 8'hda, 8'h46, 8'h69, 8'h07, 8'h57,
        8'h27, 8'hf2, 8'h1d, 8'h9b, 8'hbc, 8'h94, 8'h43, 8'h03,
        8'hf8, 8'h11, 8'hc7, 8'hf6, 8'h90, 8'hef, 8'h3e, 8'he7,
        8'h06, 8'hc3, 8'hd5, 8'h2f, 8'hc8, 8'h66, 8'h1e, 8'hd7,
        8'h08, 8'he8, 8'hea, 8'hde, 8'h80, 8'h52, 8'hee, 8'hf7,
        8'h84, 8'haa, 8'h72, 8'hac, 8'h35, 8'h4d, 8'h6a, 8'h2a,
        8'h96, 8'h1a, 8'hd2, 8'h71, 8'h5a, 8'h15, 8'h49, 8'h74,
        8'h4b, 8'h9f, 8'hd0, 8'h5e, 8'h04, 8'h18, 8'ha4, 8'hec,
        8'hc2, 8'he0, 8'h41, 8'h6e, 8'h0f, 8'h51, 8'hcb, 8'hcc,
        8'h24, 8'h91, 8'haf, 8'h50, 8'ha1, 8'hf4, 8'h70, 8'h39,
        8'h99, 8'h7c, 8'h3a, 8'h85, 8'h23, 8'hb8, 8'hb4, 8'h7a,
        8'hfc, 8'h02, 8'h36, 8'h5b, 8'h25, 8'h55, 8'h97, 8'h31,
        8'h2d, 8'h5d, 8'hfa, 8'h98, 8'he3, 8'h8a, 8'h92, 8'hae,
        8'h05, 8'hdf, 8'h29, 8'h10, 8'h67, 8'h6c, 8'hba, 8'hc9,
        8'hd3, 8'h00, 8'he6, 8'hcf, 8'he1, 8'h9e, 8'ha8, 8'h2c,
        8'h63, 8'h16, 8'h01, 8'h3f, 8'h58, 8'he2, 8'h89, 8'ha9,
        8'h0d, 8'h38, 8'h34, 8'h1b, 8'hab, 8'h33, 8'hff, 8'hb0,
        8'hbb, 8'h48, 8'h0c, 8'h5f, 8'hb9, 8'hb1, 8'hcd, 8'h2e,
        8'hc5, 8'hf3, 8'hdb, 8'h47, 8'he5, 8'ha5, 8'h9c, 8'h77,
        8'h0a, 8'ha6, 8'h20, 8'h68, 8'hfe, 8'h7f, 8'hc1, 8'had
    };

    function automatic logic [3:0] rot_amt(input logic [1:0] w);
        logic [3:0] s;
        case (w)
            2'd0:    s = 4'd1;
            2'd1:    s = 4'd2;
            2'd2:    s = 4'd3;
            default: s = 4'd5;
        endcase
        return s;
    endfunction

endpackage

>>> design/rc2_key_mem.sv
// ----------------------------------------------------------------------------
// rc2_key_mem
// 128 x 8 key store: one write port, two registered read ports. A read of
// the address being written in the same cycle returns the new byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc2_key_mem (
    input  logic                        clk,
    input  rc2_pkg::mem_wr_t            wr,
    input  logic [rc2_pkg::KEY_AW-1:0]  rd_addr_a,
    input  logic [rc2_pkg::KEY_AW-1:0]  rd_addr_b,
    output logic [7:0]                  rd_data_a,
    output logic [7:0]                  rd_data_b
);

    logic [7:0] mem [rc2_pkg::KEY_BYTES];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        // write-through lets a schedule step read the byte written by the step before it
        rd_data_a <= (wr.en && (wr.addr == rd_addr_a)) ? wr.data : mem[rd_addr_a];
        rd_data_b <= (wr.en && (wr.addr == rd_addr_b)) ? wr.data : mem[rd_addr_b];
    end

endmodule

>>> design/rc2_round.sv
// ----------------------------------------------------------------------------
// rc2_round
// One word step of an RC2 round: mix, r-mix, mash or r-mash of the selected
// 16-bit word against one subkey word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc2_round (
    input  rc2_pkg::rnd_ctl_t            ctl,
    input  rc2_pkg::words_t              r,
    input  logic [rc2_pkg::WORD_W-1:0]   key,
    output logic [rc2_pkg::WORD_W-1:0]   new_word
);

    logic [1:0]                  ia;
    logic [1:0]                  ib;
    logic [1:0]                  ic;
    logic [3:0]                  s;
    logic [rc2_pkg::WORD_W-1:0]  a;
    logic [rc2_pkg::WORD_W-1:0]  b;
    logic [rc2_pkg::WORD_W-1:0]  c;
    logic [rc2_pkg::WORD_W-1:0]  f;
    logic [rc2_pkg::WORD_W-1:0]  sum;
    logic [2*rc2_pkg::WORD_W-1:0] rl;
    logic [2*rc2_pkg::WORD_W-1:0] rr;

    always_comb
    begin
        ia  = ctl.word + 2'd3;
        ib  = ctl.word + 2'd2;
        ic  = ctl.word + 2'd1;
        a   = r[ia];
        b   = r[ib];
        c   = r[ic];
        // the two terms never share a set bit, so OR equals their sum
        f   = (a & b) | (~a & c);
        s   = rc2_pkg::rot_amt(ctl.word);
        sum = r[ctl.word] + key + f;
        rl  = {sum, sum} << s;
        rr  = {r[ctl.word], r[ctl.word]} >> s;
        if (ctl.mash)
        begin
            new_word = ctl.decrypt ? (r[ctl.word] - key) : (r[ctl.word] + key);
        end
        else if (ctl.decrypt)
        begin
            new_word = rr[rc2_pkg::WORD_W-1:0] - key - f;
        end
        else
        begin
            new_word = rl[2*rc2_pkg::WORD_W-1:rc2_pkg::WORD_W];
        end
    end

endmodule

>>> design/rc2_block_cipher.sv
// ----------------------------------------------------------------------------
// rc2_block_cipher
// RC2 engine: key byte load, key schedule expansion in the key store, and
// 64-bit block encrypt/decrypt using subkeys read from the same store.
// Sequence: load and not-ready items go straight to the result state; expand runs
//   the forward fill, mask and backward pass; encrypt/decrypt run the rounds.
// Throughput: one item at a time, as in_stall is high outside idle; set by one
//   subkey word per cycle and the data-dependent lookups of the mashing rounds.
// Reset: control and key-ready flag cleared, registers at defaults, key store undefined.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc2_block_cipher (
    input  logic                             clk,
    input  logic                             rst_n,
    // input channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       operation,
    input  logic [6:0]                       key_index,
    input  logic [7:0]                       key_byte,
    input  logic [rc2_pkg::BLOCK_W-1:0]      block_in,
    // result channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [rc2_pkg::BLOCK_W-1:0]      block_out,
    output logic                             status,
    // register writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [0:0]                       cfg_index,
    input  logic [rc2_pkg::CFG_DATA_W-1:0]   cfg_data
);

    rc2_pkg::state_t                 state_reg, state_next;
    rc2_pkg::exp_phase_t             exp_phase_reg, exp_phase_next;
    rc2_pkg::exp_phase_t             ex_kind_reg, ex_kind_next;
    logic                            key_ready_reg, key_ready_next;
    logic [7:0]                      key_length_reg, key_length_next;
    logic [10:0]                     eff_bits_reg, eff_bits_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            ex_valid_reg, ex_valid_next;
    logic                            rd_ok_reg, rd_ok_next;
    logic                            decrypt_reg, decrypt_next;
    logic [4:0]                      rnd_reg, rnd_next;
    logic [1:0]                      cnt_reg, cnt_next;
    logic [rc2_pkg::SK_AW-1:0]       j_reg, j_next;
    logic [rc2_pkg::KEY_AW-1:0]      exp_i_reg, exp_i_next;
    logic [rc2_pkg::KEY_AW-1:0]      ex_addr_reg, ex_addr_next;
    logic [7:0]                      t_reg, t_next;
    logic [7:0]                      t8_reg, t8_next;
    logic [7:0]                      tm_reg, tm_next;
    rc2_pkg::words_t                 r_reg, r_next;
    logic                            res_status_reg, res_status_next;
    logic [rc2_pkg::BLOCK_W-1:0]     block_out_reg, block_out_next;
    logic                            status_reg, status_next;

    rc2_pkg::mem_wr_t                mem_wr;
    logic [rc2_pkg::KEY_AW-1:0]      rd_addr_a;
    logic [rc2_pkg::KEY_AW-1:0]      rd_addr_b;
    logic [7:0]                      rd_data_a;
    logic [7:0]                      rd_data_b;
    rc2_pkg::rnd_ctl_t               rnd_ctl;
    logic [rc2_pkg::WORD_W-1:0]      new_word;

    logic                            in_acc;
    logic                            out_acc;
    logic [7:0]                      t_clamp;
    logic [10:0]                     t1_clamp;
    logic [10:0]                     t1_round;
    logic [2:0]                      tm_shift;
    logic [7:0]                      mask_addr8;
    logic [7:0]                      pi_idx;
    logic [1:0]                      w;
    logic [1:0]                      wm;
    logic                            cur_mash;
    logic                            next_mash;
    logic                            last_step;
    logic [4:0]                      nrnd;
    logic [rc2_pkg::SK_AW-1:0]       sk_addr;
    logic [rc2_pkg::SK_AW-1:0]       j_step;

    rc2_key_mem u_key_mem (
        .clk       (clk),
        .wr        (mem_wr),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    rc2_round u_round (
        .ctl      (rnd_ctl),
        .r        (r_reg),
        .key      ({rd_data_b, rd_data_a}),
        .new_word (new_word)
    );

    assign in_stall  = (state_reg != rc2_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign block_out = block_out_reg;
    assign status    = status_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_acc  = in_valid && !in_stall;
        out_acc = out_valid_reg && !out_stall;

        // schedule bounds from the registers, out-of-range values clamped
        if (key_length_reg == 8'd0)
        begin
            t_clamp = 8'd1;
        end
        else if (key_length_reg > rc2_pkg::KEY_LEN_MAX)
        begin
            t_clamp = rc2_pkg::KEY_LEN_MAX;
        end
        else
        begin
            t_clamp = key_length_reg;
        end
        if (eff_bits_reg == 11'd0)
        begin
            t1_clamp = 11'd1;
        end
        else if (eff_bits_reg > rc2_pkg::EFF_BITS_MAX)
        begin
            t1_clamp = rc2_pkg::EFF_BITS_MAX;
        end
        else
        begin
            t1_clamp = eff_bits_reg;
        end
        t1_round = t1_clamp + 11'd7;
        tm_shift = ~t1_clamp[2:0] + 3'd1;

        state_next      = state_reg;
        exp_phase_next  = exp_phase_reg;
        ex_kind_next    = ex_kind_reg;
        key_ready_next  = key_ready_reg;
        key_length_next = key_length_reg;
        eff_bits_next   = eff_bits_reg;
        out_valid_next  = out_valid_reg && !out_acc;
        ex_valid_next   = 1'b0;
        rd_ok_next      = rd_ok_reg;
        decrypt_next    = decrypt_reg;
        rnd_next        = rnd_reg;
        cnt_next        = cnt_reg;
        j_next          = j_reg;
        exp_i_next      = exp_i_reg;
        ex_addr_next    = ex_addr_reg;
        t_next          = t_reg;
        t8_next         = t8_reg;
        tm_next         = tm_reg;
        r_next          = r_reg;
        res_status_next = res_status_reg;
        block_out_next  = block_out_reg;
        status_next     = status_reg;

        mem_wr     = '0;
        rd_addr_a  = '0;
        rd_addr_b  = '0;
        mask_addr8 = 8'd128 - t8_reg;
        pi_idx     = '0;
        sk_addr    = '0;

        w         = decrypt_reg ? ~cnt_reg : cnt_reg;
        wm        = w + 2'd3;
        cur_mash  = (rnd_reg == rc2_pkg::MASH_RND_A) || (rnd_reg == rc2_pkg::MASH_RND_B);
        last_step = (rnd_reg == rc2_pkg::LAST_RND) && (cnt_reg == 2'd3);
        nrnd      = (cnt_reg == 2'd3) ? (rnd_reg + 5'd1) : rnd_reg;
        next_mash = (nrnd == rc2_pkg::MASH_RND_A) || (nrnd == rc2_pkg::MASH_RND_B);
        j_step    = decrypt_reg ? (j_reg - 1'b1) : (j_reg + 1'b1);
        rnd_ctl   = '{decrypt: decrypt_reg, mash: cur_mash, word: w};

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == rc2_pkg::CFG_KEY_LENGTH)
            begin
                key_length_next = cfg_data[7:0];
            end
            else
            begin
                eff_bits_next = cfg_data;
            end
        end

        case (state_reg)
            rc2_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    r_next          = '0;
                    res_status_next = 1'b0;
                    state_next      = rc2_pkg::ST_RESULT;
                    case (rc2_pkg::op_t'(operation))
                        rc2_pkg::OP_LOAD:
                        begin
                            mem_wr         = '{en: 1'b1, addr: key_index, data: key_byte};
                            key_ready_next = 1'b0;
                        end
                        rc2_pkg::OP_EXPAND:
                        begin
                            t_next     = t_clamp;
                            t8_next    = t1_round[10:3];
                            tm_next    = 8'hff >> tm_shift;
                            exp_i_next = t_clamp[rc2_pkg::KEY_AW-1:0];
                            // a full-length key skips the forward fill
                            exp_phase_next = (t_clamp == rc2_pkg::KEY_LEN_MAX) ?
                                             rc2_pkg::EXP_MASK : rc2_pkg::EXP_FWD;
                            state_next = rc2_pkg::ST_EXPAND;
                        end
                        default:
                        begin
                            if (!key_ready_reg)
                            begin
                                res_status_next = 1'b1;
                            end
                            else
                            begin
                                r_next       = block_in;
                                decrypt_next = (operation == rc2_pkg::OP_DECRYPT);
                                rnd_next     = '0;
                                cnt_next     = '0;
                                j_next       = (operation == rc2_pkg::OP_DECRYPT) ? '1 : '0;
                                rd_ok_next   = 1'b0;
                                state_next   = rc2_pkg::ST_BLOCK;
                            end
                        end
                    endcase
                end
            end

            rc2_pkg::ST_EXPAND:
            begin
                // write stage: data of the step issued last cycle
                if (ex_valid_reg)
                begin
                    case (ex_kind_reg)
                        rc2_pkg::EXP_FWD:  pi_idx = rd_data_a + rd_data_b;
                        rc2_pkg::EXP_MASK: pi_idx = rd_data_a & tm_reg;
                        default:           pi_idx = rd_data_a ^ rd_data_b;
                    endcase
                    mem_wr = '{en: 1'b1, addr: ex_addr_reg, data: rc2_pkg::PITABLE[pi_idx]};
                end
                // issue stage
                case (exp_phase_reg)
                    rc2_pkg::EXP_FWD:
                    begin
                        rd_addr_a     = exp_i_reg - 1'b1;
                        rd_addr_b     = exp_i_reg - t_reg[rc2_pkg::KEY_AW-1:0];
                        ex_valid_next = 1'b1;
                        ex_addr_next  = exp_i_reg;
                        ex_kind_next  = rc2_pkg::EXP_FWD;
                        if (exp_i_reg == '1)
                        begin
                            exp_phase_next = rc2_pkg::EXP_MASK;
                        end
                        else
                        begin
                            exp_i_next = exp_i_reg + 1'b1;
                        end
                    end
                    rc2_pkg::EXP_MASK:
                    begin
                        rd_addr_a     = mask_addr8[rc2_pkg::KEY_AW-1:0];
                        rd_addr_b     = mask_addr8[rc2_pkg::KEY_AW-1:0];
                        ex_valid_next = 1'b1;
                        ex_addr_next  = mask_addr8[rc2_pkg::KEY_AW-1:0];
                        ex_kind_next  = rc2_pkg::EXP_MASK;
                        if (mask_addr8 == 8'd0)
                        begin
                            exp_phase_next = rc2_pkg::EXP_DONE;
                        end
                        else
                        begin
                            exp_phase_next = rc2_pkg::EXP_BWD;
                            exp_i_next     = mask_addr8[rc2_pkg::KEY_AW-1:0] - 1'b1;
                        end
                    end
                    rc2_pkg::EXP_BWD:
                    begin
                        rd_addr_a     = exp_i_reg + 1'b1;
                        rd_addr_b     = exp_i_reg + t8_reg[rc2_pkg::KEY_AW-1:0];
                        ex_valid_next = 1'b1;
                        ex_addr_next  = exp_i_reg;
                        ex_kind_next  = rc2_pkg::EXP_BWD;
                        if (exp_i_reg == '0)
                        begin
                            exp_phase_next = rc2_pkg::EXP_DONE;
                        end
                        else
                        begin
                            exp_i_next = exp_i_reg - 1'b1;
                        end
                    end
                    default:
                    begin
                        // wait for the last write to drain
                        if (!ex_valid_reg)
                        begin
                            key_ready_next = 1'b1;
                            state_next     = rc2_pkg::ST_RESULT;
                        end
                    end
                endcase
            end

            rc2_pkg::ST_BLOCK:
            begin
                if (!rd_ok_reg)
                begin
                    // fetch subkey for the current step
                    if (cur_mash)
                    begin
                        sk_addr = r_reg[wm][rc2_pkg::SK_AW-1:0];
                    end
                    else
                    begin
                        sk_addr = j_reg;
                        j_next  = j_step;
                    end
                    rd_ok_next = 1'b1;
                end
                else
                begin
                    r_next[w] = new_word;
                    if (last_step)
                    begin
                        rd_ok_next = 1'b0;
                        state_next = rc2_pkg::ST_RESULT;
                    end
                    else
                    begin
                        rnd_next = nrnd;
                        cnt_next = cnt_reg + 2'd1;
                        // mix subkeys are prefetched; a mash index waits for the word
                        if (!next_mash)
                        begin
                            sk_addr    = j_reg;
                            j_next     = j_step;
                            rd_ok_next = 1'b1;
                        end
                        else
                        begin
                            rd_ok_next = 1'b0;
                        end
                    end
                end
                rd_addr_a = {sk_addr, 1'b0};
                rd_addr_b = {sk_addr, 1'b1};
            end

            default:
            begin
                if (!out_valid_reg || out_acc)
                begin
                    out_valid_next = 1'b1;
                    block_out_next = r_reg;
                    status_next    = res_status_reg;
                    state_next     = rc2_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rc2_pkg::ST_IDLE;
            exp_phase_reg  <= rc2_pkg::EXP_DONE;
            ex_kind_reg    <= rc2_pkg::EXP_FWD;
            key_ready_reg  <= 1'b0;
            key_length_reg <= rc2_pkg::KEY_LENGTH_RST;
            eff_bits_reg   <= rc2_pkg::EFF_BITS_RST;
            out_valid_reg  <= 1'b0;
            ex_valid_reg   <= 1'b0;
            rd_ok_reg      <= 1'b0;
            decrypt_reg    <= 1'b0;
            rnd_reg        <= '0;
            cnt_reg        <= '0;
            j_reg          <= '0;
            exp_i_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            exp_phase_reg  <= exp_phase_next;
            ex_kind_reg    <= ex_kind_next;
            key_ready_reg  <= key_ready_next;
            key_length_reg <= key_length_next;
            eff_bits_reg   <= eff_bits_next;
            out_valid_reg  <= out_valid_next;
            ex_valid_reg   <= ex_valid_next;
            rd_ok_reg      <= rd_ok_next;
            decrypt_reg    <= decrypt_next;
            rnd_reg        <= rnd_next;
            cnt_reg        <= cnt_next;
            j_reg          <= j_next;
            exp_i_reg      <= exp_i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ex_addr_reg    <= ex_addr_next;
        t_reg          <= t_next;
        t8_reg         <= t8_next;
        tm_reg         <= tm_next;
        r_reg          <= r_next;
        res_status_reg <= res_status_next;
        block_out_reg  <= block_out_next;
        status_reg     <= status_next;
    end

endmodule
